>>> rtl/core/csc_pkg.sv
// Shared types, constants and time-arithmetic functions for the clock / stopwatch / timer block.
package csc_pkg;

    localparam int SecsPerMin  = 60;
    localparam int HoursPerDay = 24;
    localparam int LastUnit    = 59;

    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_SET_CLOCK   = 3'd1,
        OP_ENTER_WATCH = 3'd2,
        OP_ENTER_CLOCK = 3'd3,
        OP_TOGGLE_RUN  = 3'd4,
        OP_LOAD_TIMER  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        MODE_CLOCK = 2'd0,
        MODE_WATCH = 2'd1,
        MODE_TIMER = 2'd2
    } mode_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } hms_t;

    // One event beat as taken from the input register.
    typedef struct packed {
        op_t        op;
        logic [6:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
    } event_t;

    // Display and status view after an event.
    typedef struct packed {
        hms_t  shown;
        mode_t mode;
        logic  watch_led;
        logic  timer_led;
        logic  buzzer;
        logic  watch_running;
    } result_t;

    // Forward one second with wrap after 23:59:59.
    function automatic hms_t hms_advance(hms_t t);
        hms_t r;
        r = t;
        if (t.seconds >= 6'(LastUnit)) begin
            r.seconds = '0;
            if (t.minutes >= 6'(LastUnit)) begin
                r.minutes = '0;
                if (t.hours >= 5'(HoursPerDay - 1)) begin
                    r.hours = '0;
                end else begin
                    r.hours = t.hours + 5'd1;
                end
            end else begin
                r.minutes = t.minutes + 6'd1;
            end
        end else begin
            r.seconds = t.seconds + 6'd1;
        end
        return r;
    endfunction

    // Back one second; the caller guarantees the value is not zero.
    function automatic hms_t hms_count_down(hms_t t);
        hms_t r;
        r = t;
        if (t.seconds != '0) begin
            r.seconds = t.seconds - 6'd1;
        end else if (t.minutes != '0) begin
            r.minutes = t.minutes - 6'd1;
            r.seconds = 6'(LastUnit);
        end else begin
            r.hours   = t.hours - 5'd1;
            r.minutes = 6'(LastUnit);
            r.seconds = 6'(LastUnit);
        end
        return r;
    endfunction

    // Out-of-range keypad entries load as zero.
    function automatic hms_t hms_from_entry(event_t ev);
        hms_t r;
        r.hours   = (ev.hours >= 7'(HoursPerDay)) ? 5'd0 : ev.hours[4:0];
        r.minutes = (ev.minutes >= 7'(SecsPerMin)) ? 6'd0 : ev.minutes[5:0];
        r.seconds = (ev.seconds >= 7'(SecsPerMin)) ? 6'd0 : ev.seconds[5:0];
        return r;
    endfunction

endpackage

>>> rtl/core/csc_engine.sv
// Counter state registers and the combinational event update of the clock, stopwatch and timer.
module csc_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  csc_pkg::event_t    ev,
    output csc_pkg::result_t   result
);

    csc_pkg::hms_t  clock_reg, clock_next;
    csc_pkg::hms_t  watch_reg, watch_next;
    csc_pkg::hms_t  count_reg, count_next;
    csc_pkg::mode_t mode_reg, mode_next;
    logic           running_reg, running_next;
    logic           buzzer_reg, buzzer_next;

    always_comb begin
        clock_next   = clock_reg;
        watch_next   = watch_reg;
        count_next   = count_reg;
        mode_next    = mode_reg;
        running_next = running_reg;
        buzzer_next  = buzzer_reg;

        case (ev.op)
            csc_pkg::OP_TICK: begin
                clock_next = csc_pkg::hms_advance(clock_reg);
                if (mode_reg == csc_pkg::MODE_WATCH && running_reg) begin
                    watch_next = csc_pkg::hms_advance(watch_reg);
                end
                if (mode_reg == csc_pkg::MODE_TIMER) begin
                    if (count_reg == '0) begin
                        buzzer_next = ~buzzer_reg;
                    end else begin
                        count_next = csc_pkg::hms_count_down(count_reg);
                    end
                end
            end
            csc_pkg::OP_SET_CLOCK: begin
                if (mode_reg == csc_pkg::MODE_CLOCK) begin
                    clock_next = csc_pkg::hms_from_entry(ev);
                end
            end
            csc_pkg::OP_ENTER_WATCH: begin
                mode_next    = csc_pkg::MODE_WATCH;
                running_next = 1'b1;
                watch_next   = '0;
            end
            csc_pkg::OP_ENTER_CLOCK: begin
                mode_next = csc_pkg::MODE_CLOCK;
            end
            csc_pkg::OP_TOGGLE_RUN: begin
                running_next = ~running_reg;
            end
            csc_pkg::OP_LOAD_TIMER: begin
                count_next = csc_pkg::hms_from_entry(ev);
                mode_next  = csc_pkg::MODE_TIMER;
            end
            default: begin
            end
        endcase

        if (mode_next != csc_pkg::MODE_TIMER) begin
            buzzer_next = 1'b0;
        end

        case (mode_next)
            csc_pkg::MODE_WATCH: result.shown = watch_next;
            csc_pkg::MODE_TIMER: result.shown = count_next;
            default:             result.shown = clock_next;
        endcase
        result.mode          = mode_next;
        result.watch_led     = (mode_next == csc_pkg::MODE_WATCH);
        result.timer_led     = (mode_next == csc_pkg::MODE_TIMER);
        result.buzzer        = buzzer_next;
        result.watch_running = running_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg   <= '{hours: 5'd12, minutes: 6'd0, seconds: 6'd0};
            watch_reg   <= '0;
            count_reg   <= '0;
            mode_reg    <= csc_pkg::MODE_CLOCK;
            running_reg <= 1'b0;
            buzzer_reg  <= 1'b0;
        end else if (step_en) begin
            clock_reg   <= clock_next;
            watch_reg   <= watch_next;
            count_reg   <= count_next;
            mode_reg    <= mode_next;
            running_reg <= running_next;
            buzzer_reg  <= buzzer_next;
        end
    end

    a_clock_range: assert property (@(posedge aclk) disable iff (!aresetn)
        clock_reg.hours < 5'(csc_pkg::HoursPerDay) && clock_reg.minutes < 6'(csc_pkg::SecsPerMin)
        && clock_reg.seconds < 6'(csc_pkg::SecsPerMin))
        else $error("clock counter out of range");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg.hours < 5'(csc_pkg::HoursPerDay) && count_reg.minutes < 6'(csc_pkg::SecsPerMin)
        && count_reg.seconds < 6'(csc_pkg::SecsPerMin))
        else $error("timer counter out of range");

    a_buzzer_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        buzzer_reg |-> mode_reg == csc_pkg::MODE_TIMER)
        else $error("buzzer driven outside timer mode");

    a_watch_start: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && ev.op == csc_pkg::OP_ENTER_WATCH
        |=> running_reg && watch_reg == '0 && mode_reg == csc_pkg::MODE_WATCH)
        else $error("stopwatch did not restart");

endmodule

>>> rtl/core/clock_stopwatch_countdown.sv
// Top level of the clock / stopwatch / countdown timer: stream handshake and pipeline registers.
// A beat accepted into the input register is applied to the counters and captured in the
// result register, which drives m_tdata; a stalled result register holds it in the input register.
// Throughput: one event per cycle while m_tready keeps the result register draining.
// Reset (aresetn low, synchronous) empties both pipeline registers and loads 12:00:00 in
// clock mode, stopwatch and timer at zero, stopwatch paused and buzzer off.
module clock_stopwatch_countdown (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // set_hours [6:0], set_minutes [13:7], set_seconds [20:14]
    input  logic [2:0]  s_tuser,   // op [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // shown_hours [4:0], shown_minutes [10:5],
                                   // shown_seconds [16:11], stopwatch_led [17],
                                   // timer_led [18], buzzer [19], stopwatch_running [20]
    output logic [1:0]  m_tuser    // active_mode [1:0]
);

    // Input register holds one event; the result register holds the view after it.
    logic              in_valid_reg;
    csc_pkg::event_t   in_event_reg;
    logic              out_valid_reg;
    csc_pkg::result_t  out_result_reg;
    csc_pkg::result_t  result;
    logic              out_free;
    logic              step_en;

    // The result register can take a new beat when it is empty or being drained now.
    assign out_free = !out_valid_reg || m_tready;
    // The event in the input register is applied to the counters as it moves on.
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (step_en) begin
                in_valid_reg <= 1'b0;
            end
            if (step_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_event_reg.op      <= csc_pkg::op_t'(s_tuser);
            in_event_reg.hours   <= s_tdata[6:0];
            in_event_reg.minutes <= s_tdata[13:7];
            in_event_reg.seconds <= s_tdata[20:14];
        end
        if (step_en) begin
            out_result_reg <= result;
        end
    end

    csc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .ev      (in_event_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_result_reg.watch_running,
                       out_result_reg.buzzer,
                       out_result_reg.timer_led,
                       out_result_reg.watch_led,
                       out_result_reg.shown.seconds,
                       out_result_reg.shown.minutes,
                       out_result_reg.shown.hours};
    assign m_tuser  = out_result_reg.mode;

endmodule
